>>> rtl/core/sorted_list_table_core_macros.svh
// Assertion macros for the sorted list table core.
`ifndef SORTED_LIST_TABLE_CORE_MACROS_SVH
`define SORTED_LIST_TABLE_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SLT_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define SLT_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define SLT_ASSERT(label, clk, rstn, prop)
`define SLT_ASSERT_RST(label, clk, prop)
`endif
`endif

>>> rtl/core/slt_pkg.sv
`default_nettype none
package slt_pkg;
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_GET    = 2'd1;
    localparam logic [1:0] OP_RM_AT  = 2'd2;
    localparam logic [1:0] OP_RM_VAL = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] value;
        logic [7:0]         position;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] data;
        logic [8:0]         entry_count;
    } rsp_t;

    // datapath commands
    typedef struct packed {
        logic load;     // capture request, reset index
        logic rd;       // read entry at index
        logic step_up;  // index + 1
        logic step_dn;  // index - 1
        logic set_cnt;  // index <= count (insert shift start)
        logic set_pos;  // index <= position
        logic mv_dn;    // write rdata at idx+1 (shift toward end)
        logic mv_up;    // write rdata at idx-1
        logic wr_val;   // mem[idx] <= value
        logic cnt_inc;
        logic cnt_dec;
        logic keep_rd;  // capture rdata as data result
        logic keep_idx; // capture index as data result
    } cmd_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic       full;
        logic       pos_ok;   // position < count
        logic       idx_end;  // index == count
        logic       idx_zero; // index == 0
        logic       gt;       // registered entry > value
        logic       eq;       // registered entry == value
    } sts_t;
endpackage
`default_nettype wire

>>> rtl/core/slt_datapath.sv
`default_nettype none
module slt_datapath #(
    parameter int CAPACITY = 256
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire slt_pkg::req_t req,
    input  wire slt_pkg::cmd_t cmd,
    output slt_pkg::sts_t      sts,
    output logic [31:0]        data_q,
    output logic [$clog2(CAPACITY+1)-1:0] cnt_q
);
    import slt_pkg::*;
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 8) ? CW : 8;

    logic [31:0]   mem [CAPACITY];
    logic [31:0]   rdata_reg;
    logic [CW-1:0] idx_reg, cnt_reg;
    logic [1:0]    op_reg;
    logic [31:0]   val_reg;
    logic [7:0]    pos_reg;
    logic [31:0]   dout_reg;

    // request capture and index walk
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            if (cmd.cnt_inc) cnt_reg <= cnt_reg + 1'b1;
            if (cmd.cnt_dec) cnt_reg <= cnt_reg - 1'b1;
        end
        if (cmd.load) begin
            op_reg  <= req.opcode;
            val_reg <= req.value;
            pos_reg <= req.position;
            idx_reg <= '0;
            dout_reg <= '0;
        end
        if (cmd.step_up) idx_reg <= idx_reg + 1'b1;
        if (cmd.step_dn) idx_reg <= idx_reg - 1'b1;
        if (cmd.set_cnt) idx_reg <= cnt_reg;
        if (cmd.set_pos) idx_reg <= CW'(pos_reg);
        if (cmd.keep_rd) dout_reg <= rdata_reg;
        if (cmd.keep_idx) dout_reg <= 32'(idx_reg);
    end

    // single-port table, registered read
    always_ff @(posedge aclk) begin
        if (cmd.rd) rdata_reg <= mem[idx_reg[AW-1:0]];
        if (cmd.wr_val) mem[idx_reg[AW-1:0]] <= val_reg;
        if (cmd.mv_dn) mem[AW'(idx_reg + 1'b1)] <= rdata_reg;
        if (cmd.mv_up) mem[AW'(idx_reg - 1'b1)] <= rdata_reg;
    end

    assign sts.opcode   = op_reg;
    assign sts.full     = (cnt_reg == CW'(CAPACITY));
    assign sts.pos_ok   = (PW'(pos_reg) < PW'(cnt_reg));
    assign sts.idx_end  = (idx_reg == cnt_reg);
    assign sts.idx_zero = (idx_reg == '0);
    assign sts.gt       = ($signed(rdata_reg) > $signed(val_reg));
    assign sts.eq       = (rdata_reg == val_reg);
    assign data_q       = dout_reg;
    assign cnt_q        = cnt_reg;
endmodule
`default_nettype wire

>>> rtl/core/slt_ctrl.sv
`default_nettype none
`include "sorted_list_table_core_macros.svh"
module slt_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [1:0]         status,
    input  wire slt_pkg::sts_t sts,
    output slt_pkg::cmd_t      cmd
);
    import slt_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DISP = 4'd1;
    localparam logic [3:0] S_SRD  = 4'd2;  // search: read issued
    localparam logic [3:0] S_SCHK = 4'd3;  // search: compare
    localparam logic [3:0] S_IRD  = 4'd4;  // insert: step to idx-1 or place at 0
    localparam logic [3:0] S_IRQ  = 4'd5;  // insert: read idx
    localparam logic [3:0] S_ICHK = 4'd6;  // insert: compare, shift up
    localparam logic [3:0] S_IPUT = 4'd7;  // insert: write value at idx
    localparam logic [3:0] S_GRD  = 4'd8;
    localparam logic [3:0] S_GET  = 4'd9;
    localparam logic [3:0] S_CRD  = 4'd10; // close gap: read idx
    localparam logic [3:0] S_CWR  = 4'd11; // close gap: write idx-1
    localparam logic [3:0] S_DONE = 4'd12;
    localparam logic [3:0] S_OUT  = 4'd13;

    logic [3:0] state_reg, state_next;
    logic [1:0] status_reg, status_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            status_reg <= ST_OK;
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    // Insert walks idx down from count: each entry greater than the value
    // moves up one slot; the value lands just above the first entry that
    // is not greater, or at slot zero.
    always_comb begin
        state_next  = state_reg;
        status_next = status_reg;
        cmd         = '0;
        s_ready     = (state_reg == S_IDLE);
        m_valid     = (state_reg == S_OUT);
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                status_next = ST_OK;
                unique case (sts.opcode) inside
                    OP_INSERT: begin
                        if (sts.full) begin
                            status_next = ST_FULL;
                            state_next  = S_OUT;
                        end else begin
                            cmd.set_cnt = 1'b1;
                            state_next  = S_IRD;
                        end
                    end
                    OP_GET, OP_RM_AT: begin
                        if (!sts.pos_ok) begin
                            status_next = ST_MISS;
                            state_next  = S_OUT;
                        end else begin
                            cmd.set_pos = 1'b1;
                            state_next  = S_GRD;
                        end
                    end
                    default: begin
                        state_next = S_SRD;
                    end
                endcase
            end
            // insert: from the end, move entries up while they exceed value
            S_IRD: begin
                if (sts.idx_zero) begin
                    cmd.wr_val = 1'b1;
                    state_next = S_DONE;
                end else begin
                    cmd.step_dn = 1'b1;
                    state_next  = S_IRQ;
                end
            end
            S_IRQ: begin
                cmd.rd     = 1'b1;
                state_next = S_ICHK;
            end
            S_ICHK: begin
                if (sts.gt) begin
                    // entry moves one slot higher
                    cmd.mv_dn = 1'b1;
                    if (sts.idx_zero) begin
                        state_next = S_IPUT;
                    end else begin
                        cmd.step_dn = 1'b1;
                        state_next  = S_IRQ;
                    end
                end else begin
                    cmd.step_up = 1'b1;
                    state_next  = S_IPUT;
                end
            end
            S_IPUT: begin
                cmd.wr_val = 1'b1;
                state_next = S_DONE;
            end
            S_GRD: begin
                cmd.rd     = 1'b1;
                state_next = S_GET;
            end
            S_GET: begin
                cmd.keep_rd = 1'b1;
                if (sts.opcode == OP_GET) begin
                    state_next = S_OUT;
                end else begin
                    cmd.step_up = 1'b1;
                    state_next  = S_CRD;
                end
            end
            // remove by value: linear search of valid entries
            S_SRD: begin
                if (sts.idx_end) begin
                    status_next = ST_MISS;
                    state_next  = S_OUT;
                end else begin
                    cmd.rd     = 1'b1;
                    state_next = S_SCHK;
                end
            end
            S_SCHK: begin
                if (sts.eq) begin
                    cmd.keep_idx = 1'b1;
                    cmd.step_up  = 1'b1;
                    state_next   = S_CRD;
                end else begin
                    cmd.step_up = 1'b1;
                    state_next  = S_SRD;
                end
            end
            // close gap: idx points one past the hole
            S_CRD: begin
                if (sts.idx_end) begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_OUT;
                end else begin
                    cmd.rd     = 1'b1;
                    state_next = S_CWR;
                end
            end
            S_CWR: begin
                cmd.mv_up   = 1'b1;
                cmd.step_up = 1'b1;
                state_next  = S_CRD;
            end
            S_DONE: begin
                cmd.cnt_inc = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT: begin
                if (m_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign status = status_reg;

    `SLT_ASSERT(a_no_overlap, aclk, aresetn, m_valid |-> !s_ready)
    `SLT_ASSERT(a_out_hold, aclk, aresetn, (m_valid && !m_ready) |=> m_valid)
    `SLT_ASSERT(a_accept_leaves, aclk, aresetn, (s_valid && s_ready) |=> !s_ready)
endmodule
`default_nettype wire

>>> rtl/core/sorted_list_table_core.sv
// Sorted list table: keeps up to CAPACITY signed 32-bit values in ascending
// order in a single-port table and serves one request at a time. Insert and
// removals walk the table entry by entry through the one read-or-write table
// port, driven by the search and shift sequencer, so their time grows with
// the entry count; a get reads its position directly. One result beat per request.
`default_nettype none
module sorted_list_table_core #(
    parameter int CAPACITY = 256
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire slt_pkg::req_t s_payload,
    output logic               m_valid,
    input  wire logic          m_ready,
    output slt_pkg::rsp_t      m_payload
);
    import slt_pkg::*;
    localparam int CW = $clog2(CAPACITY + 1);

    cmd_t          cmd;
    sts_t          sts;
    logic [31:0]   data_q;
    logic [CW-1:0] cnt_q;
    logic [1:0]    status;

    slt_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
        .status, .sts, .cmd
    );

    slt_datapath #(.CAPACITY(CAPACITY)) u_dp (
        .aclk, .aresetn, .req(s_payload), .cmd, .sts, .data_q, .cnt_q
    );

    assign m_payload.status      = status;
    assign m_payload.data        = (status == ST_OK) ? data_q : '0;
    assign m_payload.entry_count = 9'(cnt_q);
endmodule
`default_nettype wire

>>> bench/sorted_list_table_checker.sv
`default_nettype none
module sorted_list_table_checker (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    input  wire logic          s_ready,
    input  wire slt_pkg::req_t s_payload,
    input  wire logic          m_valid,
    input  wire logic          m_ready,
    input  wire slt_pkg::rsp_t m_payload,
    output int                 fail_count,
    output int                 pending_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import slt_pkg::*;

    localparam int DEPTH = 256;

    logic signed [31:0] table_vals [DEPTH];
    int                 table_len;
    rsp_t               expected_rsps [$];

    assign pending_count = expected_rsps.size();

    // shift entries above idx down by one slot
    function automatic void drop_entry(int idx);
        for (int i = idx; i + 1 < table_len; i++) begin
            table_vals[i] = table_vals[i + 1];
        end
        table_len--;
    endfunction

    // apply one request to the shadow table, return its response
    function automatic rsp_t apply_request(req_t rq);
        rsp_t r;
        int   at;
        int   hit;
        r.status = ST_OK;
        r.data   = '0;
        case (rq.opcode) inside
            OP_INSERT: begin
                if (table_len >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    at = table_len;
                    for (int i = 0; i < table_len; i++) begin
                        if (table_vals[i] > rq.value) begin
                            at = i;
                            break;
                        end
                    end
                    for (int i = table_len; i > at; i--) begin
                        table_vals[i] = table_vals[i - 1];
                    end
                    table_vals[at] = rq.value;
                    table_len++;
                end
            end
            OP_GET, OP_RM_AT: begin
                if (int'(rq.position) < table_len) begin
                    r.data = table_vals[rq.position];
                    if (rq.opcode == OP_RM_AT) begin
                        drop_entry(int'(rq.position));
                    end
                end else begin
                    r.status = ST_MISS;
                end
            end
            default: begin
                hit = -1;
                for (int i = 0; i < table_len; i++) begin
                    if (table_vals[i] == rq.value) begin
                        hit = i;
                        break;
                    end
                end
                if (hit >= 0) begin
                    r.data = hit;
                    drop_entry(hit);
                end else begin
                    r.status = ST_MISS;
                end
            end
        endcase
        r.entry_count = table_len[8:0];
        return r;
    endfunction

    // predict on request beats, compare on response beats
    always @(posedge aclk) begin
        rsp_t want;
        if (!aresetn) begin
            table_len  = 0;
            fail_count = 0;
            expected_rsps.delete();
        end else begin
            if (s_valid && s_ready) begin
                expected_rsps.push_back(apply_request(s_payload));
            end
            if (m_valid && m_ready) begin
                if (expected_rsps.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("unexpected response beat %p", m_payload);
                    end
                end else begin
                    want = expected_rsps.pop_front();
                    if (want.status !== m_payload.status || want.data !== m_payload.data
                            || want.entry_count !== m_payload.entry_count) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("mismatch: expected %p, got %p", want, m_payload);
                        end
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

>>> bench/tb_top.sv
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import slt_pkg::*;

    localparam int  RANDOM_ITEMS = 889;
    localparam longint CYCLE_LIMIT = 64'd3000000;

    logic  aclk = 1'b0;
    logic  aresetn = 1'b0;
    logic  s_valid = 1'b0;
    logic  s_ready;
    req_t  s_payload = '0;
    logic  m_valid;
    logic  m_ready = 1'b0;
    rsp_t  m_payload;
    int    fail_count;
    int    pending_count;
    longint cycle_count = 0;
    bit    long_hold = 1'b0;
    logic signed [31:0] recent_vals [$];
    int    shadow_len = 0;

    sorted_list_table_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload)
    );

    sorted_list_table_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // run-away guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL sorted_list_table_core");
            $finish;
        end
    end

    // send one request beat after a random gap; valid stays up between
    // back-to-back beats
    task automatic send_req(logic [1:0] op, logic signed [31:0] v, logic [7:0] p);
        int gap;
        gap = $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= '{opcode: op, value: v, position: p};
        do @(posedge aclk); while (!s_ready);
        // rough length tracking to steer the random mix
        if (op == OP_INSERT) begin
            if (shadow_len < 256) shadow_len++;
            recent_vals.push_back(v);
            if (recent_vals.size() > 32) void'(recent_vals.pop_front());
        end
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return $signed(32'($urandom_range(0, 15))) - 8;
            default: return $signed($urandom());
        endcase
    endfunction

    // response side: random stalls plus one long hold-off
    initial begin
        int hold_gap;
        @(posedge aclk iff aresetn);
        forever begin
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (600) @(posedge aclk);
                long_hold = 1'b0;
            end
            hold_gap = ($urandom_range(0, 2) != 0) ? int'($urandom_range(0, 12)) : 0;
            if (hold_gap > 0) begin
                m_ready <= 1'b0;
                repeat (hold_gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        int op_pick;
        logic [1:0] op;
        logic signed [31:0] v;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty-table misses, extremes, duplicates, all ops
        send_req(OP_GET, 0, 8'd0);
        send_req(OP_RM_AT, 0, 8'd255);
        send_req(OP_RM_VAL, 5, 8'd0);
        send_req(OP_INSERT, 32'sh7fff_ffff, 8'd0);
        send_req(OP_INSERT, 32'sh8000_0000, 8'd255);
        send_req(OP_INSERT, 0, 8'd0);
        send_req(OP_INSERT, -1, 8'd0);
        send_req(OP_INSERT, 0, 8'd0);
        send_req(OP_INSERT, 7, 8'd0);
        send_req(OP_GET, 0, 8'd0);
        send_req(OP_GET, 0, 8'd5);
        send_req(OP_GET, 0, 8'd6);
        send_req(OP_GET, 0, 8'd255);
        send_req(OP_RM_VAL, 0, 8'd0);
        send_req(OP_RM_VAL, 12345, 8'd0);
        send_req(OP_RM_AT, 0, 8'd0);
        send_req(OP_RM_AT, 0, 8'd3);
        send_req(OP_RM_VAL, 32'sh7fff_ffff, 8'd0);
        send_req(OP_RM_AT, 0, 8'd9);

        // fill to capacity while the receiver holds off, then hit the full case
        long_hold = 1'b1;
        for (int i = 0; i < 258; i++) begin
            send_req(OP_INSERT, (i % 3 == 0) ? pick_value() : $signed($urandom()), 8'd0);
        end
        send_req(OP_GET, 0, 8'd255);
        send_req(OP_RM_AT, 0, 8'd255);
        send_req(OP_INSERT, 32'sh8000_0000, 8'd0);
        send_req(OP_RM_VAL, 32'sh8000_0000, 8'd0);
        shadow_len = 256;

        // random mix; drain the table down over time, keep it moderately full
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            op_pick = $urandom_range(0, 99);
            if (op_pick < (shadow_len > 40 ? 15 : 40)) op = OP_INSERT;
            else if (op_pick < 60) op = OP_GET;
            else if (op_pick < 80) op = OP_RM_AT;
            else op = OP_RM_VAL;
            v = pick_value();
            if (op == OP_RM_VAL && recent_vals.size() > 0 && $urandom_range(0, 3) != 0) begin
                v = recent_vals[$urandom_range(0, recent_vals.size() - 1)];
            end
            send_req(op, v, (shadow_len > 0 && $urandom_range(0, 4) != 0)
                ? 8'($urandom_range(0, shadow_len - 1)) : 8'($urandom()));
            if (op == OP_RM_AT || op == OP_RM_VAL) begin
                if (shadow_len > 0) shadow_len--;
            end
        end
        s_valid <= 1'b0;

        // drain then settle
        @(posedge aclk);
        wait (pending_count == 0);
        repeat (600) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("PASS sorted_list_table_core");
        end else begin
            $display("FAIL sorted_list_table_core");
        end
        $finish;
    end
endmodule
`default_nettype wire
